// ===== hdl/hex_listing_byte_decoder_defines.svh =====
// Assertion macros shared by the decoder's modules.
// Every property is sampled on the rising edge of clk and is off during reset.
`ifndef HEX_LISTING_BYTE_DECODER_DEFINES_SVH
`define HEX_LISTING_BYTE_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define HLBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HLBD_ASSERT_IMPL(lbl, ante, cons, msg) \
  `HLBD_ASSERT(lbl, (ante) |-> (cons), msg)
`define HLBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  `HLBD_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define HLBD_ASSERT(lbl, prop, msg)
`define HLBD_ASSERT_IMPL(lbl, ante, cons, msg)
`define HLBD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/hlbd_pkg.sv =====
package hlbd_pkg;

  localparam int MAX_KEYWORD_DEF = 8;
  localparam int MAX_BYTES_DEF   = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int COUNT_CFG_W  = 13;
  localparam int KEY_LEN_W    = 4;

  localparam logic [COUNT_CFG_W-1:0] BYTE_COUNT_RESET = 13'd2048;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_CHARS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_LENGTH = 2'd2;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_LF     = 8'd10;

  // One classified character as it waits between front and back.
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       eol;
    logic       dollar;
    logic       hex_digit;
    logic [3:0] nibble;
  } entry_t;

  // Configuration registers as seen by the back end.
  typedef struct packed {
    logic [COUNT_CFG_W-1:0] byte_count;
    logic [CFG_DATA_W-1:0]  keyword_chars;
    logic [KEY_LEN_W-1:0]   key_length;
  } cfg_t;

endpackage

// ===== hdl/hlbd_front.sv =====
module hlbd_front (
  input  logic                 in_valid,
  input  logic [7:0]           in_text_char,
  input  logic                 in_end_of_input,
  input  logic                 q_full,
  output logic                 in_stall,
  output logic                 push,
  output hlbd_pkg::entry_t     entry
);

  logic is_dec;
  logic is_uhex;

  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;

  assign is_dec  = (in_text_char >= hlbd_pkg::CHAR_ZERO) &&
                   (in_text_char <= hlbd_pkg::CHAR_NINE);
  assign is_uhex = (in_text_char >= hlbd_pkg::CHAR_UPPER_A) &&
                   (in_text_char <= hlbd_pkg::CHAR_UPPER_F);

  always_comb begin
    entry.ch        = in_text_char;
    entry.eoi       = in_end_of_input;
    entry.eol       = (in_text_char == hlbd_pkg::CHAR_CR) ||
                      (in_text_char == hlbd_pkg::CHAR_LF);
    entry.dollar    = (in_text_char == hlbd_pkg::CHAR_DOLLAR);
    entry.hex_digit = is_dec | is_uhex;
    if (is_dec) begin
      entry.nibble = 4'(in_text_char - hlbd_pkg::CHAR_ZERO);
    end else begin
      entry.nibble = 4'(in_text_char - hlbd_pkg::CHAR_UPPER_A + 8'd10);
    end
  end

endmodule

// ===== hdl/hlbd_queue.sv =====
`include "hex_listing_byte_decoder_defines.svh"

module hlbd_queue #(
  parameter int DEPTH = hlbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hlbd_pkg::entry_t  push_entry,
  input  logic              pop,
  output logic              q_valid,
  output logic              q_full,
  output hlbd_pkg::entry_t  head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  hlbd_pkg::entry_t mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == CntW'(DEPTH));
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  `HLBD_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CntW'(DEPTH), "queue count beyond depth")
  `HLBD_ASSERT_NEXT(a_pop_drains, pop && !push && count_r == CntW'(1), !q_valid,
                    "queue not empty after its last entry was taken")
  `HLBD_ASSERT_IMPL(a_no_push_when_full, q_full, !push, "queue written while full")

endmodule

// ===== hdl/hlbd_back.sv =====
`include "hex_listing_byte_decoder_defines.svh"

module hlbd_back #(
  parameter int MAX_KEYWORD = hlbd_pkg::MAX_KEYWORD_DEF,
  parameter int MAX_BYTES   = hlbd_pkg::MAX_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hlbd_pkg::cfg_t    cfg,
  input  logic              restart,
  input  logic              q_valid,
  input  hlbd_pkg::entry_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_data_byte,
  output logic              out_has_data,
  output logic              out_is_last,
  output logic              out_success
);

  localparam int CntW = $clog2(MAX_BYTES + 1);
  localparam int CmpW = (CntW > hlbd_pkg::COUNT_CFG_W) ? CntW : hlbd_pkg::COUNT_CFG_W;
  localparam int PosW = $clog2(MAX_KEYWORD + 1);

  logic            hex_active_r, hex_active_nxt;
  logic [7:0]      value_acc_r, value_acc_nxt;
  logic [CntW-1:0] bytes_left_r, bytes_left_nxt;
  logic            keyword_seen_r, keyword_seen_nxt;
  logic            line_start_r, line_start_nxt;
  logic [PosW-1:0] match_pos_r, match_pos_nxt;
  logic            match_ok_r, match_ok_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      data_r, data_nxt;
  logic            has_data_r, has_data_nxt;
  logic            last_r, last_nxt;
  logic            success_r, success_nxt;

  logic [CmpW-1:0] cnt_wide;
  logic [CntW-1:0] cnt_load;
  logic [PosW-1:0] klen;
  logic [7:0]      key_char;
  logic            emit;

  // Clamp the configured count into one to MAX_BYTES.
  always_comb begin
    cnt_wide = CmpW'(cfg.byte_count);
    if (cnt_wide == '0) begin
      cnt_wide = CmpW'(1);
    end
    if (cnt_wide > CmpW'(MAX_BYTES)) begin
      cnt_wide = CmpW'(MAX_BYTES);
    end
    cnt_load = CntW'(cnt_wide);
  end

  assign klen = (cfg.key_length > hlbd_pkg::KEY_LEN_W'(MAX_KEYWORD)) ?
                PosW'(MAX_KEYWORD) : PosW'(cfg.key_length);
  assign key_char = cfg.keyword_chars[8 * 3'(match_pos_r) +: 8];

  assign pop       = q_valid & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;
  assign out_data_byte = data_r;
  assign out_has_data  = has_data_r;
  assign out_is_last   = last_r;
  assign out_success   = success_r;

  always_comb begin
    hex_active_nxt   = hex_active_r;
    value_acc_nxt    = value_acc_r;
    bytes_left_nxt   = bytes_left_r;
    keyword_seen_nxt = keyword_seen_r;
    line_start_nxt   = line_start_r;
    match_pos_nxt    = match_pos_r;
    match_ok_nxt     = match_ok_r;
    emit             = 1'b0;
    data_nxt         = data_r;
    has_data_nxt     = has_data_r;
    last_nxt         = last_r;
    success_nxt      = success_r;

    if (restart) begin
      hex_active_nxt   = 1'b0;
      value_acc_nxt    = '0;
      bytes_left_nxt   = cnt_load;
      keyword_seen_nxt = 1'b0;
      line_start_nxt   = 1'b1;
      match_pos_nxt    = '0;
      match_ok_nxt     = 1'b1;
    end else if (pop) begin
      if (head.eoi) begin
        hex_active_nxt   = 1'b0;
        value_acc_nxt    = '0;
        bytes_left_nxt   = cnt_load;
        keyword_seen_nxt = 1'b0;
        line_start_nxt   = 1'b1;
        match_pos_nxt    = '0;
        match_ok_nxt     = 1'b1;
        if (bytes_left_r != '0) begin
          emit         = 1'b1;
          data_nxt     = '0;
          has_data_nxt = 1'b0;
          last_nxt     = 1'b1;
          success_nxt  = 1'b0;
        end
      end else if (bytes_left_r != '0) begin
        // Keyword compare first, then line end, then number decoding.
        if (line_start_r) begin
          if (match_pos_r < klen) begin
            if (key_char != head.ch) begin
              match_ok_nxt = 1'b0;
            end
            match_pos_nxt = match_pos_r + 1'b1;
          end
          if (!match_ok_nxt) begin
            line_start_nxt = 1'b0;
          end else if (match_pos_nxt >= klen) begin
            keyword_seen_nxt = 1'b1;
            line_start_nxt   = 1'b0;
          end
        end
        if (head.eol) begin
          line_start_nxt = 1'b1;
          match_pos_nxt  = '0;
          match_ok_nxt   = 1'b1;
        end
        if (head.dollar) begin
          hex_active_nxt = 1'b1;
          value_acc_nxt  = '0;
        end else if (head.hex_digit) begin
          if (hex_active_r) begin
            value_acc_nxt = {value_acc_r[3:0], head.nibble};
          end
        end else if (hex_active_r) begin
          hex_active_nxt = 1'b0;
          bytes_left_nxt = bytes_left_r - 1'b1;
          emit           = 1'b1;
          data_nxt       = value_acc_r;
          has_data_nxt   = 1'b1;
          last_nxt       = (bytes_left_r == CntW'(1));
          success_nxt    = (bytes_left_r == CntW'(1)) & keyword_seen_nxt;
        end
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_active_r   <= 1'b0;
      bytes_left_r   <= '0;
      keyword_seen_r <= 1'b0;
      line_start_r   <= 1'b1;
      match_pos_r    <= '0;
      match_ok_r     <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      hex_active_r   <= hex_active_nxt;
      bytes_left_r   <= bytes_left_nxt;
      keyword_seen_r <= keyword_seen_nxt;
      line_start_r   <= line_start_nxt;
      match_pos_r    <= match_pos_nxt;
      match_ok_r     <= match_ok_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_acc_r <= value_acc_nxt;
    data_r      <= data_nxt;
    has_data_r  <= has_data_nxt;
    last_r      <= last_nxt;
    success_r   <= success_nxt;
  end

  `HLBD_ASSERT_IMPL(a_success_on_last, out_valid_r && success_r, last_r,
                    "success flagged on a word that does not close the request")
  `HLBD_ASSERT_IMPL(a_empty_is_fail, out_valid_r && !has_data_r, last_r && !success_r,
                    "word without data is not a failed close")
  `HLBD_ASSERT_NEXT(a_count_close, !restart && pop && emit && has_data_nxt && last_nxt,
                    bytes_left_r == '0, "request closed by count but bytes remain")

endmodule

// ===== hdl/hex_listing_byte_decoder.sv =====
// Hex listing byte decoder.
// The input channel (in_valid, in_stall, in_text_char, in_end_of_input) takes one
// character word per cycle unless in_stall is high. '$' opens a number, upper-case
// hex digits shift into an 8-bit value, and any other character closes it and yields
// a byte word on the output channel (out_valid, out_stall, out_data_byte, out_has_data,
// out_is_last, out_success). At every line start the first characters are compared
// with the configured keyword. The word carrying the byte_count-th byte has out_is_last set,
// with out_success telling whether the keyword was seen; an end-of-input word on an
// open request yields a failure word without data. Characters that produce nothing
// yield no output word.
// The character is registered in the queue, and the back end registers its word in
// the output register. One character per cycle is sustained and the back end handles
// one queue entry per cycle while out_stall is low.
// When out_stall is held, the output register keeps its word, the back end stops,
// the four-entry queue fills and in_stall rises once it is full.
// Reset (synchronous, rst_n low) restores the register defaults and opens a fresh
// request; a write to a register through cfg_valid/cfg_index/cfg_data (always ready)
// also opens a fresh request, through a registered restart pulse, using the new values.
module hex_listing_byte_decoder #(
  parameter int MAX_KEYWORD = hlbd_pkg::MAX_KEYWORD_DEF,
  parameter int MAX_BYTES   = hlbd_pkg::MAX_BYTES_DEF,
  parameter int QUEUE_DEPTH = hlbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_text_char,
  input  logic                            in_end_of_input,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_data_byte,
  output logic                            out_has_data,
  output logic                            out_is_last,
  output logic                            out_success,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hlbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hlbd_pkg::CFG_DATA_W-1:0] cfg_data
);

  hlbd_pkg::cfg_t   cfg_r, cfg_nxt;
  logic             restart_r, restart_nxt;
  logic             push;
  logic             pop;
  logic             q_valid;
  logic             q_full;
  hlbd_pkg::entry_t push_entry;
  hlbd_pkg::entry_t head;

  // Registers are always writable; software must only write while the block is idle (not checked).
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt     = cfg_r;
    restart_nxt = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        hlbd_pkg::REG_BYTE_COUNT: begin
          cfg_nxt.byte_count = cfg_data[hlbd_pkg::COUNT_CFG_W-1:0];
          restart_nxt        = 1'b1;
        end
        hlbd_pkg::REG_KEYWORD_CHARS: begin
          cfg_nxt.keyword_chars = cfg_data;
          restart_nxt           = 1'b1;
        end
        hlbd_pkg::REG_KEYWORD_LENGTH: begin
          cfg_nxt.key_length = cfg_data[hlbd_pkg::KEY_LEN_W-1:0];
          restart_nxt        = 1'b1;
        end
        default: begin
          // Writes past the register list are dropped.
          restart_nxt = 1'b0;
        end
      endcase
    end
  end

  // The restart pulse is set during reset so that the back end loads its
  // byte counter from the freshly reset registers as soon as reset is released.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.byte_count    <= hlbd_pkg::BYTE_COUNT_RESET;
      cfg_r.keyword_chars <= '0;
      cfg_r.key_length    <= '0;
      restart_r           <= 1'b1;
    end else begin
      cfg_r     <= cfg_nxt;
      restart_r <= restart_nxt;
    end
  end

  hlbd_front u_front (
    .in_valid        (in_valid),
    .in_text_char    (in_text_char),
    .in_end_of_input (in_end_of_input),
    .q_full          (q_full),
    .in_stall        (in_stall),
    .push            (push),
    .entry           (push_entry)
  );

  hlbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_full     (q_full),
    .head       (head)
  );

  hlbd_back #(
    .MAX_KEYWORD (MAX_KEYWORD),
    .MAX_BYTES   (MAX_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .restart       (restart_r),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data_byte (out_data_byte),
    .out_has_data  (out_has_data),
    .out_is_last   (out_is_last),
    .out_success   (out_success)
  );

endmodule

// ===== test/hex_listing_byte_decoder_test.sv =====
module hex_listing_byte_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape. The drain pause covers the pipeline registers, the four-entry
  // queue and one receiver stall, so characters that yield no word are surely
  // consumed before a register write starts a new request.
  localparam int CLK_HALF        = 5;
  localparam int DRAIN_CYCLES    = 16;
  localparam int HOLD_OFF_CYCLES = 40;
  localparam int RANDOM_ITEMS    = 1525;
  localparam int NUM_PHASES      = 12;
  localparam int PRESSURE_PHASE  = 6;

  // Index 3 is decoded by the port but names no register.
  localparam logic [hlbd_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  typedef logic [hlbd_pkg::COUNT_CFG_W-1:0] count_t;
  typedef logic [hlbd_pkg::KEY_LEN_W-1:0]   key_len_t;

  // One word of the result channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       is_last;
    logic       success;
  } byte_word_t;

  // How a directed row is checked: by the line decoder below, as "no word at
  // all", or against a word typed into the row.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_WORD} check_t;
  typedef enum logic {ROW_CHAR, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [7:0]                      ch;
    logic                            eoi;
    logic [hlbd_pkg::CFG_IDX_W-1:0]  idx;
    logic [hlbd_pkg::CFG_DATA_W-1:0] data;
    check_t                          check;
    byte_word_t                      word;
  } plan_row_t;

  typedef struct packed {
    logic [hlbd_pkg::CFG_IDX_W-1:0]  idx;
    logic [hlbd_pkg::CFG_DATA_W-1:0] data;
  } reg_write_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } char_item_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [7:0]                      in_text_char;
  logic                            in_end_of_input;
  logic                            out_valid;
  logic                            out_stall;
  logic [7:0]                      out_data_byte;
  logic                            out_has_data;
  logic                            out_is_last;
  logic                            out_success;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [hlbd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hlbd_pkg::CFG_DATA_W-1:0] cfg_data;

  hex_listing_byte_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_char   (in_text_char),
    .in_end_of_input(in_end_of_input),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_has_data   (out_has_data),
    .out_is_last    (out_is_last),
    .out_success    (out_success),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Words the decoder still owes us, oldest first.
  byte_word_t  expected_words[$];
  reg_write_t  staged_writes[$];
  plan_row_t   plan[$];
  bit          failed = 1'b0;
  // When calm is set neither side idles. A raised hold_off makes the receiver
  // stall for a long stretch at its next word.
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;

  // ---------------------------------------------------------------------------
  // Line decoder: our own picture of the block's registers and request state.
  // ---------------------------------------------------------------------------
  count_t                          set_count;
  logic [hlbd_pkg::CFG_DATA_W-1:0] set_keyword;
  key_len_t                        set_key_len;
  logic                            in_number;
  logic [7:0]                      number_acc;
  count_t                          bytes_to_go;
  logic                            key_seen;
  logic                            at_line_start;
  key_len_t                        key_pos;
  logic                            key_matching;

  // Lengths above the keyword buffer compare the whole buffer.
  function automatic int key_len_used();
    return (set_key_len > hlbd_pkg::MAX_KEYWORD_DEF) ? hlbd_pkg::MAX_KEYWORD_DEF
                                                     : int'(set_key_len);
  endfunction

  // A fresh request: the byte budget is reloaded, with zero read as one and
  // anything above the maximum cut down to it.
  function automatic void open_request();
    in_number     = 1'b0;
    number_acc    = '0;
    key_seen      = 1'b0;
    at_line_start = 1'b1;
    key_pos       = '0;
    key_matching  = 1'b1;
    if (set_count == '0)
      bytes_to_go = count_t'(1);
    else if (set_count > hlbd_pkg::MAX_BYTES_DEF)
      bytes_to_go = count_t'(hlbd_pkg::MAX_BYTES_DEF);
    else
      bytes_to_go = set_count;
  endfunction

  function automatic void reset_registers();
    set_count   = hlbd_pkg::BYTE_COUNT_RESET;
    set_keyword = '0;
    set_key_len = '0;
    open_request();
  endfunction

  // Every write to a real register restarts the request; the spare index
  // leaves everything alone.
  function automatic void apply_write(logic [hlbd_pkg::CFG_IDX_W-1:0] idx,
                                      logic [hlbd_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      hlbd_pkg::REG_BYTE_COUNT: begin
        set_count = data[hlbd_pkg::COUNT_CFG_W-1:0];
        open_request();
      end
      hlbd_pkg::REG_KEYWORD_CHARS: begin
        set_keyword = data;
        open_request();
      end
      hlbd_pkg::REG_KEYWORD_LENGTH: begin
        set_key_len = data[hlbd_pkg::KEY_LEN_W-1:0];
        open_request();
      end
      default: ;
    endcase
  endfunction

  // Takes one character word and returns 1 with the word it causes, if any.
  // Within a character the keyword compare runs first, then the CR/LF line
  // start, then the number decoding.
  function automatic bit decode_char(input logic [7:0] ch, input logic eoi,
                                     output byte_word_t w);
    bit was_open;
    w = '0;
    if (eoi) begin
      // End of input drops any pending number. Only an open request reports
      // the failure; a closed one just restarts quietly.
      was_open = (bytes_to_go != '0);
      open_request();
      w.is_last = 1'b1;
      return was_open;
    end
    if (bytes_to_go == '0)
      return 1'b0;

    if (at_line_start) begin
      if (key_pos < key_len_used()) begin
        if (set_keyword[key_pos[2:0]*8 +: 8] != ch)
          key_matching = 1'b0;
        key_pos = key_pos + 1'b1;
      end
      // An empty keyword is found on the very first character of a line.
      if (!key_matching) begin
        at_line_start = 1'b0;
      end else if (key_pos >= key_len_used()) begin
        key_seen      = 1'b1;
        at_line_start = 1'b0;
      end
    end

    if (ch == hlbd_pkg::CHAR_CR || ch == hlbd_pkg::CHAR_LF) begin
      at_line_start = 1'b1;
      key_pos       = '0;
      key_matching  = 1'b1;
    end

    if (ch == hlbd_pkg::CHAR_DOLLAR) begin
      in_number  = 1'b1;
      number_acc = '0;
    end else if (ch >= hlbd_pkg::CHAR_ZERO && ch <= hlbd_pkg::CHAR_NINE) begin
      if (in_number)
        number_acc = {number_acc[3:0], ch[3:0]};
    end else if (ch >= hlbd_pkg::CHAR_UPPER_A && ch <= hlbd_pkg::CHAR_UPPER_F) begin
      if (in_number)
        number_acc = {number_acc[3:0], 4'(ch - hlbd_pkg::CHAR_UPPER_A + 8'd10)};
    end else if (in_number) begin
      // Any other character, lower-case hex included, closes the number.
      in_number   = 1'b0;
      bytes_to_go = bytes_to_go - 1'b1;
      w.data_byte = number_acc;
      w.has_data  = 1'b1;
      w.is_last   = (bytes_to_go == '0);
      w.success   = (bytes_to_go == '0) && key_seen;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(int unsigned n);
    return (n < 10) ? 8'(hlbd_pkg::CHAR_ZERO + n) : 8'(hlbd_pkg::CHAR_UPPER_A + (n - 10));
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers.
  // ---------------------------------------------------------------------------

  // Offers one character word after a random gap and holds it until the
  // block takes it. The line decoder runs at the accepting edge.
  task automatic send_char(input logic [7:0] ch, input logic eoi,
                           input check_t check, input byte_word_t pinned);
    int         gap;
    bit         made;
    byte_word_t w;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_text_char    <= ch;
    in_end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    made = decode_char(ch, eoi, w);
    if (check == CHK_WORD)
      expected_words.push_back(pinned);
    else if (check == CHK_MODEL && made)
      expected_words.push_back(w);
  endtask

  // Drops the input valid, waits for every owed word, then lets the block
  // chew through any characters that produce nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the staged registers back to back; the valid drops only after the
  // last one so it is never lowered and raised within one step.
  task automatic commit_writes();
    reg_write_t wr;
    while (staged_writes.size() != 0) begin
      wr = staged_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= wr.idx;
      cfg_data  <= wr.data;
      do @(posedge clk); while (!cfg_ready);
      apply_write(wr.idx, wr.data);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic void plan_char(logic [7:0] ch, logic eoi, check_t check,
                                    byte_word_t word);
    plan_row_t row;
    row.kind  = ROW_CHAR;
    row.ch    = ch;
    row.eoi   = eoi;
    row.idx   = REG_NONE;
    row.data  = '0;
    row.check = check;
    row.word  = word;
    plan.push_back(row);
  endfunction

  function automatic void plan_reg(logic [hlbd_pkg::CFG_IDX_W-1:0] idx,
                                   logic [hlbd_pkg::CFG_DATA_W-1:0] data);
    plan_row_t row;
    row.kind  = ROW_REG;
    row.ch    = '0;
    row.eoi   = 1'b0;
    row.idx   = idx;
    row.data  = data;
    row.check = CHK_NONE;
    row.word  = '0;
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stalls at random after each word, with one long hold-off so
  // the queue inside the block fills and pushes back on the input.
  // ---------------------------------------------------------------------------
  initial begin : word_sink
    int pause;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off) begin
        pause    = HOLD_OFF_CYCLES;
        hold_off = 1'b0;
      end else begin
        pause = calm ? 0 : $urandom_range(0, 4);
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Every accepted word is matched against the oldest one still owed.
  always @(posedge clk) begin : word_check
    byte_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: data_byte %0h has_data %0b is_last %0b success %0b",
               out_data_byte, out_has_data, out_is_last, out_success);
        failed = 1'b1;
      end else begin
        want = expected_words.pop_front();
        check_field("data_byte", want.data_byte, out_data_byte);
        check_field("has_data", want.has_data, out_has_data);
        check_field("is_last", want.is_last, out_is_last);
        check_field("success", want.success, out_success);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    char_item_t                      line[$];
    count_t                          count;
    logic [hlbd_pkg::CFG_DATA_W-1:0] keyword;
    key_len_t                        key_len;
    logic [hlbd_pkg::CFG_DATA_W-1:0] filler;
    int                              pick;
    int                              sent;
    int                              r;
    int                              k;
    int                              keep;
    int                              spot;
    logic [7:0]                      ch;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_text_char    <= '0;
    in_end_of_input <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= hlbd_pkg::REG_BYTE_COUNT;
    cfg_data        <= '0;
    reset_registers();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Out of reset the budget is 2048 bytes and the keyword
    // is empty, so it counts as seen at once.
    plan_char(hlbd_pkg::CHAR_DOLLAR, 1'b0, CHK_NONE, '0);
    plan_char("F", 1'b0, CHK_NONE, '0);
    plan_char("F", 1'b0, CHK_NONE, '0);
    plan_char(CHAR_SPACE, 1'b0, CHK_WORD, '{8'hFF, 1'b1, 1'b0, 1'b0});
    // Four digits keep only the low byte; a lower-case letter ends the number.
    plan_char(hlbd_pkg::CHAR_DOLLAR, 1'b0, CHK_MODEL, '0);
    plan_char("1", 1'b0, CHK_MODEL, '0);
    plan_char("2", 1'b0, CHK_MODEL, '0);
    plan_char("3", 1'b0, CHK_MODEL, '0);
    plan_char("A", 1'b0, CHK_MODEL, '0);
    plan_char("a", 1'b0, CHK_MODEL, '0);
    plan_char(8'h00, 1'b0, CHK_NONE, '0);
    plan_char(8'hFF, 1'b0, CHK_NONE, '0);
    // End of input on the open request reports failure without data.
    plan_char(8'hFF, 1'b1, CHK_WORD, '{8'h00, 1'b0, 1'b1, 1'b0});
    // Two bytes with the keyword "KEY" on the first line.
    plan_reg(hlbd_pkg::REG_BYTE_COUNT, 64'd2);
    plan_reg(hlbd_pkg::REG_KEYWORD_CHARS, 64'h0000_0000_0059_454B);
    plan_reg(hlbd_pkg::REG_KEYWORD_LENGTH, 64'd3);
    plan_char("K", 1'b0, CHK_MODEL, '0);
    plan_char("E", 1'b0, CHK_MODEL, '0);
    plan_char("Y", 1'b0, CHK_MODEL, '0);
    plan_char(hlbd_pkg::CHAR_DOLLAR, 1'b0, CHK_MODEL, '0);
    plan_char("4", 1'b0, CHK_MODEL, '0);
    plan_char("1", 1'b0, CHK_MODEL, '0);
    plan_char(hlbd_pkg::CHAR_LF, 1'b0, CHK_MODEL, '0);
    plan_char(hlbd_pkg::CHAR_DOLLAR, 1'b0, CHK_MODEL, '0);
    plan_char("4", 1'b0, CHK_MODEL, '0);
    plan_char("2", 1'b0, CHK_MODEL, '0);
    plan_char(hlbd_pkg::CHAR_CR, 1'b0, CHK_WORD, '{8'h42, 1'b1, 1'b1, 1'b1});
    // After the last byte characters are ignored, and end of input is silent.
    plan_char("X", 1'b0, CHK_NONE, '0);
    plan_char(8'h00, 1'b1, CHK_NONE, '0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        staged_writes.push_back('{plan[i].idx, plan[i].data});
        commit_writes();
      end else begin
        send_char(plan[i].ch, plan[i].eoi, plan[i].check, plan[i].word);
      end
    end

    // Random part, in phases. Each phase may reprogram the registers while
    // the block is idle. The first phases pin the register extremes.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();

      pick = (p < 5) ? p : $urandom_range(0, 9);
      case (pick)
        0:       count = '0;
        1:       count = '1;
        2:       count = count_t'(hlbd_pkg::MAX_BYTES_DEF);
        3:       count = count_t'(hlbd_pkg::MAX_BYTES_DEF + 1);
        4:       count = count_t'(1);
        default: count = count_t'($urandom_range(2, 16));
      endcase

      if (p == 0) begin
        keyword = '1;
      end else if (p == 1) begin
        keyword = '0;
      end else begin
        for (int b = 0; b < 8; b++) begin
          if ($urandom_range(0, 4) == 0)
            keyword[b*8 +: 8] = 8'($urandom_range(0, 255));
          else if ($urandom_range(0, 1) == 0)
            keyword[b*8 +: 8] = 8'(hlbd_pkg::CHAR_UPPER_A + $urandom_range(0, 25));
          else
            keyword[b*8 +: 8] = hex_char($urandom_range(0, 9));
        end
      end

      case (p)
        0:       key_len = '1;
        1:       key_len = key_len_t'(3);
        2:       key_len = '0;
        3:       key_len = 4'd8;
        default: key_len = ($urandom_range(0, 3) == 0) ? key_len_t'($urandom_range(0, 15))
                                                      : key_len_t'($urandom_range(1, 4));
      endcase

      // Upper data bits beyond each register's width are junk on purpose.
      if (p < 5 || $urandom_range(0, 2) != 0) begin
        filler = {$urandom, $urandom};
        filler[hlbd_pkg::COUNT_CFG_W-1:0] = count;
        staged_writes.push_back('{hlbd_pkg::REG_BYTE_COUNT, filler});
      end
      if (p < 5 || $urandom_range(0, 2) != 0)
        staged_writes.push_back('{hlbd_pkg::REG_KEYWORD_CHARS, keyword});
      if (p < 5 || $urandom_range(0, 2) != 0) begin
        filler = {$urandom, $urandom};
        filler[hlbd_pkg::KEY_LEN_W-1:0] = key_len;
        staged_writes.push_back('{hlbd_pkg::REG_KEYWORD_LENGTH, filler});
      end
      if (p == 5)
        staged_writes.push_back('{REG_NONE, {$urandom, $urandom}});
      commit_writes();

      calm = (p % 4 == 3) || (p == PRESSURE_PHASE);
      if (p == PRESSURE_PHASE)
        hold_off = 1'b1;

      sent = 0;
      while (sent < RANDOM_ITEMS / NUM_PHASES) begin
        line.delete();
        r = $urandom_range(0, 99);
        if (bytes_to_go == '0) begin
          // A closed request mostly gets its end of input soon; the rest is
          // junk that the block must swallow.
          if (r < 75)
            line.push_back('{8'($urandom_range(0, 255)), 1'b1});
          else
            line.push_back('{8'($urandom_range(0, 255)), 1'b0});
        end else if (r < 3) begin
          line.push_back('{8'($urandom_range(0, 255)), 1'b1});
        end else if (r < 12) begin
          repeat ($urandom_range(1, 3))
            line.push_back('{8'($urandom_range(0, 255)), 1'b0});
        end else begin
          // A listing line: maybe the keyword (whole, cut short or with one
          // wrong character), some numbers, then a line end.
          k = key_len_used();
          if (r < 75 && k > 0) begin
            keep = ($urandom_range(0, 5) == 0) ? $urandom_range(0, k - 1) : k;
            spot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, k - 1) : k;
            for (int i = 0; i < keep; i++) begin
              ch = (i == spot) ? 8'($urandom_range(0, 255)) : set_keyword[i*8 +: 8];
              line.push_back('{ch, 1'b0});
            end
          end
          repeat ($urandom_range(1, 4)) begin
            line.push_back('{hlbd_pkg::CHAR_DOLLAR, 1'b0});
            repeat ($urandom_range(0, 4))
              line.push_back('{hex_char($urandom_range(0, 15)), 1'b0});
            case ($urandom_range(0, 7))
              0, 1, 2: line.push_back('{CHAR_SPACE, 1'b0});
              3:       line.push_back('{CHAR_COMMA, 1'b0});
              4:       line.push_back('{8'(CHAR_LOWER_A + $urandom_range(0, 5)), 1'b0});
              5:       line.push_back('{8'($urandom_range(0, 255)), 1'b0});
              6:       line.push_back('{hlbd_pkg::CHAR_DOLLAR, 1'b0});
              default: ;
            endcase
          end
          case ($urandom_range(0, 2))
            0: line.push_back('{hlbd_pkg::CHAR_CR, 1'b0});
            1: line.push_back('{hlbd_pkg::CHAR_LF, 1'b0});
            default: begin
              line.push_back('{hlbd_pkg::CHAR_CR, 1'b0});
              line.push_back('{hlbd_pkg::CHAR_LF, 1'b0});
            end
          endcase
        end

        foreach (line[i]) begin
          // Every character offered counts toward the phase.
          sent++;
          send_char(line[i].ch, line[i].eoi, CHK_MODEL, '0);
        end
      end
    end

    settle();
    if (!failed)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Roughly ten times the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
